FILE: design/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg: shared types for the particle pool
// item structs, controller-to-datapath command and datapath-to-controller status bundles
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic [31:0] colour_end;
    logic [31:0] colour_begin;
    logic [15:0] scale_end;
    logic [15:0] scale_begin;
    logic [47:0] acceleration;
    logic [47:0] start_velocity;
    logic [47:0] start_position;
    logic [15:0] lifetime;
    logic        operation;
  } in_item_t;

  typedef struct packed {
    logic        last;
    logic        add_dropped;
    logic [31:0] vertex_colour;
    logic [15:0] vertex_scale;
    logic [47:0] vertex_position;
    logic        vertex_valid;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture slot record at read address
    logic upd;       // compute motion, age, start dividers
    logic wr_add;    // write new particle
    logic wr_upd;    // write updated particle
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic expired;   // loaded record has age >= lifetime
  } dp_sts_t;

  // saturating signed 16-bit add
  function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {a[15], a} + {b[15], b};
    if (s[16] != s[15]) sat_add16 = s[16] ? 16'h8000 : 16'h7fff;
    else sat_add16 = s[15:0];
  endfunction

  function automatic logic [47:0] vec_add_sat(input logic [47:0] a, input logic [47:0] b);
    vec_add_sat = {sat_add16(a[47:32], b[47:32]), sat_add16(a[31:16], b[31:16]),
                   sat_add16(a[15:0], b[15:0])};
  endfunction

endpackage

FILE: design/pps_lerp_div.sv
// ----------------------------------------------------------------------------
// pps_lerp_div: serial interpolation unit
// begin + trunc((end-begin)*age/life) for five channels, restoring division
// one quotient bit per cycle while dividing, channels share one multiplier and divider
// ----------------------------------------------------------------------------
module pps_lerp_div
  import pps_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] age,
  input  logic [15:0] life,
  input  logic [15:0] sc_b,
  input  logic [15:0] sc_e,
  input  logic [31:0] col_b,
  input  logic [31:0] col_e,
  output logic        done,
  output logic [15:0] scale,
  output logic [31:0] colour
);

  // one channel processed at a time: multiply phase, then 32 divide steps
  logic [2:0]  ch;
  logic [5:0]  step;
  logic        busy;
  logic        mul_ph;
  logic [31:0] num;
  logic [16:0] rem;
  logic [31:0] quo;
  logic        neg;
  logic [15:0] bsel, esel, diffm;
  logic [15:0] lifer, ager, b_cur;
  logic [16:0] rem_sh;

  always_comb begin
    unique case (ch)
      3'd0:    begin bsel = sc_b;              esel = sc_e;              end
      3'd1:    begin bsel = {8'd0, col_b[7:0]};   esel = {8'd0, col_e[7:0]};   end
      3'd2:    begin bsel = {8'd0, col_b[15:8]};  esel = {8'd0, col_e[15:8]};  end
      3'd3:    begin bsel = {8'd0, col_b[23:16]}; esel = {8'd0, col_e[23:16]}; end
      default: begin bsel = {8'd0, col_b[31:24]}; esel = {8'd0, col_e[31:24]}; end
    endcase
    diffm = (esel >= bsel) ? esel - bsel : bsel - esel;
    rem_sh = {rem[15:0], num[31]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        mul_ph <= 1'b1;
        ch     <= 3'd0;
        lifer  <= life;
        ager   <= (age > life) ? life : age;
      end else if (busy) begin
        if (mul_ph) begin
          neg    <= esel < bsel;
          b_cur  <= bsel;
          rem    <= '0;
          quo    <= '0;
          step   <= '0;
          mul_ph <= 1'b0;
          if (lifer == 16'd0) begin
            // zero lifetime yields the end value
            num   <= 32'(diffm);
            lifer <= 16'd1;
            ager  <= 16'd1;
          end else begin
            // one 16x16 multiply per channel
            num <= 32'(diffm) * 32'(ager);
          end
        end else begin
          // restoring divide step
          if (rem_sh >= {1'b0, lifer}) begin
            rem <= rem_sh - {1'b0, lifer};
            quo <= {quo[30:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[30:0], 1'b0};
          end
          num  <= {num[30:0], 1'b0};
          step <= step + 6'd1;
          if (step == 6'd31) begin
            mul_ph <= 1'b1;
            ch     <= ch + 3'd1;
            if (ch == 3'd4) begin
              busy <= 1'b0;
              done <= 1'b1;
            end
          end
        end
      end
    end
  end

  // final quotient bit folded in combinationally on the last step
  logic [31:0] qf;
  logic [15:0] res;
  assign qf  = {quo[30:0], (rem_sh >= {1'b0, lifer})};
  assign res = neg ? b_cur - qf[15:0] : b_cur + qf[15:0];

  always_ff @(posedge clk) begin
    if (busy && !mul_ph && step == 6'd31) begin
      unique case (ch)
        3'd0:    scale         <= res;
        3'd1:    colour[7:0]   <= res[7:0];
        3'd2:    colour[15:8]  <= res[7:0];
        3'd3:    colour[23:16] <= res[7:0];
        default: colour[31:24] <= res[7:0];
      endcase
    end
  end

endmodule

FILE: design/pps_datapath.sv
// ----------------------------------------------------------------------------
// pps_datapath: slot memory and per-particle update
// record memory with registered read, saturating motion, lerp unit
// ----------------------------------------------------------------------------
module pps_datapath
  import pps_pkg::*;
#(
  parameter int POOL_SLOTS = 64,
  parameter int IW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  dp_cmd_t       cmd,
  input  logic [IW-1:0] addr,
  input  in_item_t      in_item,
  output dp_sts_t       sts,
  output logic [47:0]   pos_out,
  output logic [15:0]   scale_out,
  output logic [31:0]   colour_out
);

  typedef struct packed {
    logic [63:0] col;
    logic [31:0] sc;
    logic [47:0] acc;
    logic [47:0] vel;
    logic [47:0] pos;
    logic [15:0] life;
    logic [15:0] age;
  } rec_t;

  rec_t mem [POOL_SLOTS];
  rec_t rd, upd_rec, wdata;
  logic [47:0] vel_n;

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_add || cmd.wr_upd) mem[addr] <= wdata;
    if (cmd.load) rd <= mem[addr];
    if (cmd.upd) upd_rec <= '{col: rd.col, sc: rd.sc, acc: rd.acc, vel: vel_n,
                               pos: vec_add_sat(rd.pos, vel_n), life: rd.life,
                               age: (rd.age == 16'hffff) ? rd.age : rd.age + 16'd1};
  end

  assign vel_n = vec_add_sat(rd.vel, rd.acc);

  always_comb begin
    if (cmd.wr_add)
      wdata = '{col: {in_item.colour_end, in_item.colour_begin},
                sc: {in_item.scale_end, in_item.scale_begin},
                acc: in_item.acceleration, vel: in_item.start_velocity,
                pos: in_item.start_position, life: in_item.lifetime, age: 16'd0};
    else
      wdata = upd_rec;
  end

  // lerp starts in the cycle after the motion register loads
  logic start_d;
  always_ff @(posedge clk) begin
    if (rst) start_d <= 1'b0;
    else start_d <= cmd.upd;
  end

  pps_lerp_div u_lerp (
    .clk(clk), .rst(rst), .start(start_d),
    .age(upd_rec.age), .life(upd_rec.life),
    .sc_b(upd_rec.sc[15:0]), .sc_e(upd_rec.sc[31:16]),
    .col_b(upd_rec.col[31:0]), .col_e(upd_rec.col[63:32]),
    .done(sts.div_done), .scale(scale_out), .colour(colour_out)
  );

  assign sts.expired = rd.age >= rd.life;
  assign pos_out = upd_rec.pos;

endmodule

FILE: design/pps_ctrl.sv
// ----------------------------------------------------------------------------
// pps_ctrl: pool controller
// alive bits, free slot search, freeing pass and update walk, result handshake
// ----------------------------------------------------------------------------
module pps_ctrl
  import pps_pkg::*;
#(
  parameter int POOL_SLOTS = 64,
  parameter int IW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          op,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          o_vertex,
  output logic          o_dropped,
  output logic          o_last,
  output dp_cmd_t       cmd,
  output logic [IW-1:0] addr,
  input  dp_sts_t       sts
);

  typedef enum logic [2:0] {S_IDLE, S_RD, S_CHK, S_UPD, S_DIV, S_OUT, S_NEXT} state_t;
  state_t state;
  logic [POOL_SLOTS-1:0] alive;
  logic [IW-1:0] slot;
  logic any_out;
  logic sweep;
  logic free_found;
  logic [IW-1:0] free_idx;
  logic [IW:0] slot_inc;
  logic walk_end;
  logic more_live;
  logic out_free;
  logic emit;

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx = '0;
    for (int i = POOL_SLOTS - 1; i >= 0; i--)
      if (!alive[i]) begin
        free_found = 1'b1;
        free_idx = IW'(i);
      end
  end

  assign slot_inc = {1'b0, slot} + (IW+1)'(1);
  assign walk_end = slot_inc == (IW+1)'(POOL_SLOTS);
  // any live slot above the current one after the freeing pass
  assign more_live = |((alive >> slot) >> 1);
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && !out_valid;
  assign addr = (state == S_IDLE) ? free_idx : slot;

  // result register loads
  assign emit = (state == S_IDLE && in_valid && in_ready && op == OP_ADD) ||
                (state == S_OUT && !out_valid) ||
                (state == S_NEXT && !sweep && walk_end && !any_out && out_free);

  always_comb begin
    cmd = '0;
    cmd.wr_add = (state == S_IDLE) && in_valid && in_ready && op == OP_ADD && free_found;
    cmd.load   = (state == S_RD);
    cmd.upd    = (state == S_CHK) && !sweep && alive[slot];
    cmd.wr_upd = (state == S_UPD);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      alive <= '0;
      out_valid <= 1'b0;
      slot <= '0;
      any_out <= 1'b0;
      sweep <= 1'b0;
    end else begin
      if (emit) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid && in_ready) begin
          if (op == OP_ADD) begin
            if (free_found) alive[free_idx] <= 1'b1;
            o_vertex <= 1'b0;
            o_dropped <= !free_found;
            o_last <= 1'b1;
          end else begin
            slot <= '0;
            any_out <= 1'b0;
            sweep <= 1'b1;
            state <= S_RD;
          end
        end
        S_RD: state <= S_CHK;
        S_CHK:
          if (sweep) begin
            // freeing pass: drop particles whose age reached lifetime
            if (alive[slot] && sts.expired) alive[slot] <= 1'b0;
            state <= S_NEXT;
          end else if (alive[slot]) state <= S_UPD;
          else state <= S_NEXT;
        S_UPD: state <= S_DIV;
        S_DIV: if (sts.div_done) state <= S_OUT;
        S_OUT: if (!out_valid) begin
          // last vertex when no live slot follows
          o_vertex <= 1'b1;
          o_dropped <= 1'b0;
          o_last <= !more_live;
          any_out <= 1'b1;
          state <= S_NEXT;
        end
        default: begin
          // S_NEXT: advance the walk
          if (sweep) begin
            if (walk_end) begin
              sweep <= 1'b0;
              slot <= '0;
            end else begin
              slot <= slot_inc[IW-1:0];
            end
            state <= S_RD;
          end else if (out_free) begin
            if (walk_end) begin
              if (!any_out) begin
                o_vertex <= 1'b0;
                o_dropped <= 1'b0;
                o_last <= 1'b1;
              end
              state <= S_IDLE;
            end else begin
              slot <= slot_inc[IW-1:0];
              state <= S_RD;
            end
          end
        end
      endcase
    end
  end

endmodule

FILE: design/particle_pool_step.sv
// ----------------------------------------------------------------------------
// particle_pool_step: particle pool with euler update and lerp output
// ----------------------------------------------------------------------------
// add item: result in the cycle after accept, one free-slot search of alive bits
// tick item: freeing pass takes each slot through S_RD, S_CHK, S_NEXT, then
// the update walk adds S_UPD, S_DIV (five channels of one multiply and 32
// serial divide steps), S_OUT per live slot; next item taken once result has left
// reset: synchronous, empties the pool at once, no clearing pass
module particle_pool_step
  import pps_pkg::*;
#(
  parameter int POOL_SLOTS = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam int IW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic [IW-1:0] addr;
  logic v_vertex, v_drop, v_last;
  logic [47:0] pos;
  logic [15:0] scale;
  logic [31:0] colour;
  logic [47:0] pos_q;
  logic [15:0] scale_q;
  logic [31:0] colour_q;

  pps_ctrl #(.POOL_SLOTS(POOL_SLOTS)) u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .op(in_item.operation), .out_valid(out_valid), .out_ready(out_ready),
    .o_vertex(v_vertex), .o_dropped(v_drop), .o_last(v_last),
    .cmd(cmd), .addr(addr), .sts(sts)
  );

  pps_datapath #(.POOL_SLOTS(POOL_SLOTS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .addr(addr), .in_item(in_item),
    .sts(sts), .pos_out(pos), .scale_out(scale), .colour_out(colour)
  );

  // result payload capture when the lerp unit reports done
  always_ff @(posedge clk) begin
    if (sts.div_done) begin
      pos_q <= pos;
      scale_q <= scale;
      colour_q <= colour;
    end
  end

  always_comb begin
    out_item.vertex_valid    = v_vertex;
    out_item.vertex_position = v_vertex ? pos_q : 48'd0;
    out_item.vertex_scale    = v_vertex ? scale_q : 16'd0;
    out_item.vertex_colour   = v_vertex ? colour_q : 32'd0;
    out_item.add_dropped     = v_drop;
    out_item.last            = v_last;
  end

`ifndef NO_ASSERTIONS
  a_drop_no_vertex: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.add_dropped |-> !out_item.vertex_valid && out_item.last)
    else $error("dropped add carries vertex");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid)
    else $error("input taken while result pending");
  a_write_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.wr_add && cmd.wr_upd))
    else $error("two slot writes at once");
`endif

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: particle pool testbench
// directed table of add and tick items, a fill past full, then random traffic, all checked
// against a behavioral pool model kept in the bench, with random idling
// ----------------------------------------------------------------------------
module tb_top
  import pps_pkg::*;
();

  localparam int SLOTS = 64;
  localparam int WATCHDOG_LIMIT = 200000;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;

  particle_pool_step #(.POOL_SLOTS(SLOTS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // pool model state
  logic        pool_live [SLOTS];
  logic [15:0] pool_age [SLOTS];
  logic [15:0] pool_life [SLOTS];
  logic [47:0] pool_pos [SLOTS];
  logic [47:0] pool_vel [SLOTS];
  logic [47:0] pool_acc [SLOTS];
  logic [31:0] pool_scale [SLOTS];
  logic [63:0] pool_colour [SLOTS];

  out_item_t vertex_queue[$];
  int        errors = 0;
  int        items_sent = 0;
  int        vertices_seen = 0;
  int        drops_seen = 0;
  int        idle_pct = 9;
  int        quiet_cycles = 0;

  function automatic logic [15:0] sat_lane(input logic [15:0] a, input logic [15:0] b);
    int s;
    s = $signed(a) + $signed(b);
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    return s[15:0];
  endfunction

  function automatic logic [47:0] vec_sum(input logic [47:0] a, input logic [47:0] b);
    return {sat_lane(a[47:32], b[47:32]), sat_lane(a[31:16], b[31:16]),
            sat_lane(a[15:0], b[15:0])};
  endfunction

  function automatic logic [31:0] blend(input logic [31:0] b, input logic [31:0] e,
                                        input logic [15:0] age, input logic [15:0] life);
    longint diff;
    longint a;
    if (life == 0) return e;
    a = (age > life) ? life : age;
    diff = longint'(e) - longint'(b);
    return 32'(longint'(b) + (diff * a) / longint'(life));
  endfunction

  // advance the pool model by one item and queue its results
  task automatic predict_pool(input in_item_t it);
    int slot;
    int first;
    out_item_t r;
    logic [31:0] col;
    slot = -1;
    first = vertex_queue.size();
    r = '0;
    if (it.operation == OP_ADD) begin
      for (int i = 0; i < SLOTS; i++)
        if (!pool_live[i] && slot < 0) slot = i;
      if (slot < 0) begin
        r.add_dropped = 1'b1;
      end else begin
        pool_live[slot] = 1'b1;
        pool_age[slot] = '0;
        pool_life[slot] = it.lifetime;
        pool_pos[slot] = it.start_position;
        pool_vel[slot] = it.start_velocity;
        pool_acc[slot] = it.acceleration;
        pool_scale[slot] = {it.scale_end, it.scale_begin};
        pool_colour[slot] = {it.colour_end, it.colour_begin};
      end
      r.last = 1'b1;
      vertex_queue.push_back(r);
      return;
    end
    for (int i = 0; i < SLOTS; i++)
      if (pool_live[i] && pool_age[i] >= pool_life[i]) pool_live[i] = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (pool_live[i]) begin
        if (pool_age[i] != 16'hffff) pool_age[i]++;
        pool_vel[i] = vec_sum(pool_vel[i], pool_acc[i]);
        pool_pos[i] = vec_sum(pool_pos[i], pool_vel[i]);
        r = '0;
        r.vertex_valid = 1'b1;
        r.vertex_position = pool_pos[i];
        r.vertex_scale = 16'(blend(pool_scale[i][15:0], pool_scale[i][31:16],
                                   pool_age[i], pool_life[i]));
        for (int c = 0; c < 4; c++)
          col[8*c +: 8] = 8'(blend(pool_colour[i][8*c +: 8], pool_colour[i][32+8*c +: 8],
                                   pool_age[i], pool_life[i]));
        r.vertex_colour = col;
        vertex_queue.push_back(r);
      end
    end
    if (vertex_queue.size() == first) begin
      r = '0;
      r.last = 1'b1;
      vertex_queue.push_back(r);
    end else begin
      vertex_queue[vertex_queue.size()-1].last = 1'b1;
    end
  endtask

  // directed table: kind, lifetime, vector fill, scale, colour
  typedef struct {
    logic        op;
    logic [15:0] life;
    logic [47:0] pos;
    logic [47:0] vel;
    logic [47:0] acc;
    logic [31:0] scale;
    logic [63:0] colour;
    logic        fixed_check;
    out_item_t   fixed;
  } row_t;

  row_t rows[$];

  function automatic out_item_t only_last(input logic dropped);
    out_item_t r;
    r = '0;
    r.add_dropped = dropped;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic row_t mk(input logic op, input logic [15:0] life, input logic [47:0] pos,
                              input logic [47:0] vel, input logic [47:0] acc,
                              input logic [31:0] sc, input logic [63:0] col);
    row_t w;
    w.op = op; w.life = life; w.pos = pos; w.vel = vel; w.acc = acc;
    w.scale = sc; w.colour = col; w.fixed_check = 1'b0; w.fixed = '0;
    return w;
  endfunction

  function automatic in_item_t random_item(input int add_pct);
    in_item_t it;
    it = '0;
    it.operation = ($urandom_range(99) < add_pct) ? OP_ADD : OP_TICK;
    case ($urandom_range(3))
      0: it.lifetime = 16'($urandom_range(3));
      1: it.lifetime = 16'($urandom_range(20));
      2: it.lifetime = 16'hffff;
      default: it.lifetime = 16'($urandom);
    endcase
    it.start_position = {16'($urandom), 16'($urandom), 16'($urandom)};
    it.start_velocity = {16'($urandom), 16'($urandom), 16'($urandom)};
    it.acceleration = {16'($urandom), 16'($urandom), 16'($urandom)};
    it.scale_begin = 16'($urandom);
    it.scale_end = 16'($urandom);
    it.colour_begin = $urandom;
    it.colour_end = $urandom;
    return it;
  endfunction

  // send one item, keeping valid high until it is taken
  task automatic send_item(input in_item_t it);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_item <= it;
    in_valid <= 1'b1;
    predict_pool(it);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // drop valid and wait for every expected result
  task automatic drain;
    in_valid <= 1'b0;
    do @(posedge clk); while (vertex_queue.size() != 0);
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      quiet_cycles <= 0;
      if (vertex_queue.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_item);
        errors++;
      end else begin
        out_item_t e;
        e = vertex_queue.pop_front();
        if (out_item.vertex_valid) vertices_seen++;
        if (out_item.add_dropped) drops_seen++;
        if (out_item.vertex_valid !== e.vertex_valid ||
            out_item.vertex_position !== e.vertex_position ||
            out_item.vertex_scale !== e.vertex_scale ||
            out_item.vertex_colour !== e.vertex_colour ||
            out_item.add_dropped !== e.add_dropped || out_item.last !== e.last) begin
          $display("%0t: mismatch expected %h actual %h", $time, e, out_item);
          errors++;
        end
      end
    end else if (!rst && in_valid && in_ready) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result stall
  always @(posedge clk) begin
    out_ready <= !(idle_pct > 0 && $urandom_range(99) < idle_pct);
  end

  // watchdog
  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    in_item_t it;
    out_item_t got;
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    for (int i = 0; i < SLOTS; i++) pool_live[i] = 1'b0;

    // tick on empty pool, extremes, zero lifetime, saturation
    rows.push_back(mk(OP_TICK, '0, '0, '0, '0, '0, '0));
    rows[$].fixed_check = 1'b1; rows[$].fixed = only_last(1'b0);
    rows.push_back(mk(OP_ADD, 16'hffff, {3{16'h7fff}}, {3{16'h7fff}}, {3{16'h7fff}},
                      32'hffff_0000, 64'hffffffff_00000000));
    rows.push_back(mk(OP_ADD, 16'd3, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}},
                      32'h0000_ffff, 64'h00000000_ffffffff));
    rows.push_back(mk(OP_ADD, 16'd0, 48'h1234_5678_9abc, 48'h1, 48'h1, 32'h1234_5678,
                      64'h0102_0304_f0e0_d0c0));
    rows.push_back(mk(OP_ADD, 16'd1, 48'h0, 48'hffff_0001_0100, 48'h0, 32'h0100_0200,
                      64'h80808080_7f7f7f7f));
    for (int k = 0; k < 5; k++) rows.push_back(mk(OP_TICK, '0, '0, '0, '0, '0, '0));

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[k]) begin
      it = '0;
      it.operation = rows[k].op;
      it.lifetime = rows[k].life;
      it.start_position = rows[k].pos;
      it.start_velocity = rows[k].vel;
      it.acceleration = rows[k].acc;
      {it.scale_end, it.scale_begin} = rows[k].scale;
      {it.colour_end, it.colour_begin} = rows[k].colour;
      if (rows[k].fixed_check) begin
        drain();
        send_item(it);
        got = vertex_queue[$];
        if (got !== rows[k].fixed) begin
          $display("%0t: table row %0d expected %h predicted %h", $time, k,
                   rows[k].fixed, got);
          errors++;
        end
      end else begin
        send_item(it);
      end
    end

    // fill the pool past full, check every dropped add
    drain();
    for (int k = 0; k < SLOTS + 2; k++) begin
      it = random_item(100);
      it.lifetime = 16'd12;
      send_item(it);
    end
    it = random_item(0);
    send_item(it);

    // hold off until every result is in
    drain();

    // random traffic, with a stretch with no idling
    for (int k = 0; k < 140; k++) begin
      idle_pct = (k >= 50 && k < 100) ? 0 : 9;
      it = random_item(k < 70 ? 30 : 65);
      send_item(it);
    end
    idle_pct = 9;

    drain();
    repeat (200) @(posedge clk);
    $display("tb_top: %0d items sent, %0d vertices and %0d dropped adds checked",
             items_sent, vertices_seen, drops_seen);
    if (errors == 0 && vertex_queue.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

FILE: particle_pool_step.f
design/pps_pkg.sv
design/pps_lerp_div.sv
design/pps_datapath.sv
design/pps_ctrl.sv
design/particle_pool_step.sv
verif/tb_top.sv
